[hdl/bcu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcu_pkg: shared types for the 2x bicubic upscaler
// Queue word passed from the front end to the filter pipeline, result layout
// and queue sizing.
// ----------------------------------------------------------------------------
package bcu_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // one source column slice: pix[0] oldest line, pix[3] newest pixel
    typedef struct packed {
        logic            emit;
        logic [8:0]      out_row;
        logic [8:0]      out_col;
        logic [3:0][7:0] pix;
    } bcu_word_t;

    // first member lands in the highest bits, so out_row sits at bit 0
    typedef struct packed {
        logic [7:0] px_odd_odd;
        logic [7:0] px_odd_even;
        logic [7:0] px_even_odd;
        logic [7:0] px_even_even;
        logic [8:0] out_col;
        logic [8:0] out_row;
    } bcu_result_t;

endpackage

[hdl/bicubic_upscale_2x.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bicubic_upscale_2x: streaming 2x cubic Lagrange image upscaler
// Source grey pixels in raster order; for each source pixel at row and column
// three or more, emits the 2x2 output block of the pixel two rows and two
// columns up-left of it.
//
//  port group  dir  payload
//  s_axis_*    in   tdata[7:0] pixel; tuser[0] frame_start
//  m_axis_*    out  tdata out_row, out_col, px_even_even, px_even_odd,
//                   px_odd_even, px_odd_odd (low bits first), zero pad
//  apb         in   0x0 src_width, 0x4 src_height
//
// one pixel per cycle sustained while the result side keeps up; the line memory
// is read and rewritten once per pixel on separate ports, with a bypass for
// back-to-back same-column pixels. m_axis_tvalid for a completed block is set
// after the stage-one register, the queue and the window, filter and output
// registers. the line memory needs no clearing pass after reset.
// either side may stall on its own: the four-word queue and the output
// register decouple them
// ----------------------------------------------------------------------------
module bicubic_upscale_2x #(
    parameter int MAX_WIDTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
    input  logic        s_axis_tuser,   // [0] frame_start

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [8:0] out_row, [17:9] out_col,
                                        // [25:18] px_even_even, [33:26] px_even_odd,
                                        // [41:34] px_odd_even, [49:42] px_odd_odd

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bcu_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam logic REG_SRC_WIDTH  = 1'b0;
    localparam logic REG_SRC_HEIGHT = 1'b1;

    logic [8:0]      src_width_reg, src_height_reg;
    logic            cfg_write;
    logic [CW + 8:0] width_ext;
    logic [CW - 1:0] width_eff;
    logic [8:0]      height_eff;

    logic               push, pop, q_valid;
    bcu_word_t          push_word, head_word;
    logic [QCNT_W - 1:0] q_level;
    bcu_result_t        result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 9'd256;
            src_height_reg <= 9'd256;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_SRC_WIDTH:  src_width_reg  <= pwdata[8:0];
                REG_SRC_HEIGHT: src_height_reg <= pwdata[8:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SRC_WIDTH:  prdata = {23'd0, src_width_reg};
            REG_SRC_HEIGHT: prdata = {23'd0, src_height_reg};
            default:        prdata = '0;
        endcase
    end

    // saturate the sizes to what the position logic supports
    always_comb
    begin
        width_ext = (CW + 9)'(src_width_reg);
        if (width_ext < (CW + 9)'(4))
            width_eff = CW'(4);
        else if (width_ext > (CW + 9)'(MAX_WIDTH))
            width_eff = CW'(MAX_WIDTH);
        else
            width_eff = width_ext[CW - 1:0];

        if (src_height_reg < 9'd4)
            height_eff = 9'd4;
        else if (src_height_reg > 9'd256)
            height_eff = 9'd256;
        else
            height_eff = src_height_reg;
    end

    bcu_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .width_eff   (width_eff),
        .height_eff  (height_eff),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .pixel       (s_axis_tdata),
        .frame_start (s_axis_tuser),
        .q_level     (q_level),
        .push        (push),
        .push_word   (push_word)
    );

    bcu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .not_empty (q_valid),
        .head_word (head_word),
        .level     (q_level)
    );

    bcu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_word    (head_word),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result)
    );

    assign m_axis_tdata = {6'd0, result};

endmodule

[hdl/bcu_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcu_front: position tracking and line memory
// Takes source pixels, keeps the raster position, reads and rewrites the
// three stored lines for the current column and pushes one column slice per
// pixel into the queue, marked when it completes an output block.
// ----------------------------------------------------------------------------
module bcu_front #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [$clog2(MAX_WIDTH + 1) - 1:0]  width_eff,
    input  logic [8:0]                          height_eff,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          pixel,
    input  logic                                frame_start,
    input  logic [bcu_pkg::QCNT_W - 1:0]        q_level,
    output logic                                push,
    output bcu_pkg::bcu_word_t                  push_word
);
    import bcu_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(MAX_WIDTH);

    logic [2:0][7:0] line_mem [MAX_WIDTH];
    logic [2:0][7:0] rd_data_reg;

    logic [CW - 1:0] col_pos_reg, col_pos_next;
    logic [7:0]      row_pos_reg, row_pos_next;

    logic            s1_valid_reg;
    logic            s1_hit_reg, s1_hit_next;
    logic [2:0][7:0] s1_fwd_reg;
    logic [AW - 1:0] s1_addr_reg;
    logic [7:0]      s1_px_reg;
    logic            s1_emit_reg;
    logic [8:0]      s1_row_reg;
    logic [8:0]      s1_col_reg;

    logic            accept;
    logic [CW - 1:0] c0, c;
    logic [7:0]      r0, r;
    logic [8:0]      r1;
    logic            wrap;
    logic [AW - 1:0] addr;
    logic            emit;
    logic [7:0]      row_m2;
    logic [CW + 8:0] col_m2;
    logic [2:0][7:0] line_rd;
    logic [2:0][7:0] wr_data;

    // the stage-one slot is always pushed, so leave room for it
    assign in_ready = ((QCNT_W + 1)'(q_level) + (QCNT_W + 1)'(s1_valid_reg))
                      < (QCNT_W + 1)'(QDEPTH);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        c0     = frame_start ? '0 : col_pos_reg;
        r0     = frame_start ? '0 : row_pos_reg;
        wrap   = (c0 >= width_eff);
        c      = wrap ? '0 : c0;
        r1     = {1'b0, r0} + {8'd0, wrap};
        r      = (r1 >= height_eff) ? 8'd0 : r1[7:0];
        addr   = c[AW - 1:0];
        emit   = (r >= 8'd3) && (c >= CW'(3));
        row_m2 = r - 8'd2;
        col_m2 = (CW + 9)'(c) - (CW + 9)'(2);

        col_pos_next = c + CW'(1);
        row_pos_next = r;
        s1_hit_next  = s1_valid_reg && (s1_addr_reg == addr);
    end

    // same-column write in flight at the read edge wins over memory data
    assign line_rd = s1_hit_reg ? s1_fwd_reg : rd_data_reg;
    assign wr_data = {s1_px_reg, line_rd[2], line_rd[1]};

    assign push                = s1_valid_reg;
    assign push_word.emit      = s1_emit_reg;
    assign push_word.out_row   = s1_row_reg;
    assign push_word.out_col   = s1_col_reg;
    assign push_word.pix       = {s1_px_reg, line_rd[2], line_rd[1], line_rd[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s1_hit_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                col_pos_reg <= col_pos_next;
                row_pos_reg <= row_pos_next;
                s1_hit_reg  <= s1_hit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            line_mem[s1_addr_reg] <= wr_data;
        if (accept)
        begin
            rd_data_reg <= line_mem[addr];
            s1_fwd_reg  <= wr_data;
            s1_addr_reg <= addr;
            s1_px_reg   <= pixel;
            s1_emit_reg <= emit;
            s1_row_reg  <= {row_m2, 1'b0};
            s1_col_reg  <= {col_m2[7:0], 1'b0};
        end
    end

endmodule

[hdl/bcu_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcu_queue: short word queue between front end and filter pipeline
// Register-based FIFO; the front end throttles itself on the level.
// ----------------------------------------------------------------------------
module bcu_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  bcu_pkg::bcu_word_t            push_word,
    input  logic                          pop,
    output logic                          not_empty,
    output bcu_pkg::bcu_word_t            head_word,
    output logic [bcu_pkg::QCNT_W - 1:0]  level
);
    import bcu_pkg::*;

    bcu_word_t          slot_reg [QDEPTH];
    logic [QPTR_W - 1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W - 1:0] count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign head_word = slot_reg[rd_ptr_reg];
    assign level     = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_word;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < QCNT_W'(QDEPTH)) || pop)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue read while empty");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == QCNT_W'(QDEPTH)) || (QPTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W - 1:0]))
        else $error("queue pointers disagree with level");

endmodule

[hdl/bcu_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcu_back: 4x4 window and cubic filter pipeline
// Shifts each column slice into the window, applies (-1,9,9,-1)/16 along
// rows, columns and both, and holds the 2x2 block in the output register.
// ----------------------------------------------------------------------------
module bcu_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  bcu_pkg::bcu_word_t   q_word,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bcu_pkg::bcu_result_t result
);
    import bcu_pkg::*;

    function automatic logic signed [13:0] tap_px(input logic [7:0] a, input logic [7:0] b,
                                                  input logic [7:0] c, input logic [7:0] d);
        logic signed [13:0] m;
        m = $signed({6'd0, b}) + $signed({6'd0, c});
        return (m <<< 3) + m - $signed({6'd0, a}) - $signed({6'd0, d});
    endfunction

    function automatic logic signed [17:0] tap_hs(input logic signed [13:0] a,
                                                  input logic signed [13:0] b,
                                                  input logic signed [13:0] c,
                                                  input logic signed [13:0] d);
        logic signed [17:0] m;
        m = 18'(b) + 18'(c);
        return (m <<< 3) + m - 18'(a) - 18'(d);
    endfunction

    function automatic logic [7:0] sat_u8(input logic signed [17:0] v);
        logic [7:0] q;
        if (v < 0)
            q = 8'd0;
        else if (v > 18'sd255)
            q = 8'd255;
        else
            q = v[7:0];
        return q;
    endfunction

    logic                     en;
    logic [3:0][3:0][7:0]     window_reg;
    logic                     a_emit_reg;
    logic [8:0]               a_row_reg, a_col_reg;

    logic                     b_valid_reg;
    logic signed [13:0]       b_hs_reg [4];
    logic [7:0]               b_ee_reg, b_eo_reg, b_oe_reg;
    logic [8:0]               b_row_reg, b_col_reg;

    logic                     c_valid_reg;
    bcu_result_t              c_res_reg;

    logic signed [13:0]       hs [4];
    logic signed [13:0]       vs;
    logic signed [17:0]       hs1_x, vs_x, vv;

    // whole pipeline holds while a finished block waits
    assign en        = !c_valid_reg || out_ready;
    assign pop       = en && q_valid;
    assign out_valid = c_valid_reg;
    assign result    = c_res_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            hs[i] = tap_px(window_reg[i][0], window_reg[i][1],
                           window_reg[i][2], window_reg[i][3]);
        vs    = tap_px(window_reg[0][1], window_reg[1][1],
                       window_reg[2][1], window_reg[3][1]);
        hs1_x = 18'(hs[1]);
        vs_x  = 18'(vs);
        vv    = tap_hs(b_hs_reg[0], b_hs_reg[1], b_hs_reg[2], b_hs_reg[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= '0;
            a_emit_reg  <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_emit_reg  <= q_valid && q_word.emit;
            b_valid_reg <= a_emit_reg;
            c_valid_reg <= b_valid_reg;
            if (q_valid)
            begin
                for (int i = 0; i < 4; i++)
                    window_reg[i] <= {q_word.pix[i], window_reg[i][3:1]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_row_reg <= q_word.out_row;
            a_col_reg <= q_word.out_col;

            for (int i = 0; i < 4; i++)
                b_hs_reg[i] <= hs[i];
            b_ee_reg  <= window_reg[1][1];
            b_eo_reg  <= sat_u8(hs1_x >>> 4);
            b_oe_reg  <= sat_u8(vs_x >>> 4);
            b_row_reg <= a_row_reg;
            b_col_reg <= a_col_reg;

            c_res_reg.px_odd_odd   <= sat_u8(vv >>> 8);
            c_res_reg.px_odd_even  <= b_oe_reg;
            c_res_reg.px_even_odd  <= b_eo_reg;
            c_res_reg.px_even_even <= b_ee_reg;
            c_res_reg.out_col      <= b_col_reg;
            c_res_reg.out_row      <= b_row_reg;
        end
    end

    a_pop_only_when_moving: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> en && q_valid)
        else $error("queue popped while pipeline held");

    a_emit_flows: assert property (@(posedge clk) disable iff (!rst_n)
        (en && b_valid_reg) |=> c_valid_reg)
        else $error("filtered block lost between stages");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && !out_ready) |=> $stable(window_reg) && c_valid_reg)
        else $error("window moved during output stall");

endmodule

[tb/bicubic_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bicubic_checker: scoreboard for the 2x bicubic upscaler
// Watches the pixel stream, the result stream and the register port. Keeps
// its own line memory, window and raster position, predicts the 2x2 block
// that each accepted pixel produces, and compares every result word with the
// oldest prediction. Hands a failure count and the number of outstanding
// blocks to the testbench top.
// ----------------------------------------------------------------------------
module bicubic_checker #(
    parameter int         MAX_WIDTH   = 256,
    parameter logic [2:0] WIDTH_ADDR  = 3'h0,
    parameter logic [2:0] HEIGHT_ADDR = 3'h4
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tuser,

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,

    output int          errors,
    output int          pending
);
    import bcu_pkg::*;

    localparam int MAX_HEIGHT = 256;

    logic [7:0]  line_mem [3][MAX_WIDTH];
    logic [7:0]  win [4][4];
    int          row_pos;
    int          col_pos;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [49:0] block_q [$];
    int          shown;

    function automatic int clamp_shift(input int sum, input int sh);
        int q;
        if (sum < 0)
            return 0;
        q = sum >>> sh;
        return (q > 255) ? 255 : q;
    endfunction

    // cubic lagrange taps at half phase, scaled by 16
    function automatic int half_taps(input int a, input int b, input int c, input int d);
        return 9 * (b + c) - a - d;
    endfunction

    // moves the raster position, shifts one column into the window and
    // queues the 2x2 block when the window is complete
    task automatic upscale_pixel(input logic [7:0] pix, input logic frame_start);
        int          w;
        int          h;
        int          r;
        int          c;
        int          hs [4];
        int          vs;
        int          vv;
        logic [7:0]  col [4];
        bcu_result_t blk;

        w = int'(width_reg);
        h = int'(height_reg);
        if (w < 4)
            w = 4;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        if (h < 4)
            h = 4;
        if (h > MAX_HEIGHT)
            h = MAX_HEIGHT;

        if (frame_start)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        r = row_pos;
        c = col_pos;

        col[0] = line_mem[0][c];
        col[1] = line_mem[1][c];
        col[2] = line_mem[2][c];
        col[3] = pix;
        line_mem[0][c] = col[1];
        line_mem[1][c] = col[2];
        line_mem[2][c] = pix;

        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 3; j++)
                win[i][j] = win[i][j + 1];
            win[i][3] = col[i];
        end
        col_pos = c + 1;

        if (r >= 3 && c >= 3)
        begin
            for (int i = 0; i < 4; i++)
                hs[i] = half_taps(win[i][0], win[i][1], win[i][2], win[i][3]);
            vs = half_taps(win[0][1], win[1][1], win[2][1], win[3][1]);
            vv = half_taps(hs[0], hs[1], hs[2], hs[3]);
            blk.out_row      = 9'(2 * (r - 2));
            blk.out_col      = 9'(2 * (c - 2));
            blk.px_even_even = win[1][1];
            blk.px_even_odd  = 8'(clamp_shift(hs[1], 4));
            blk.px_odd_even  = 8'(clamp_shift(vs, 4));
            blk.px_odd_odd   = 8'(clamp_shift(vv, 8));
            block_q.push_back(blk);
        end
    endtask

    task automatic check_block(input logic [55:0] word);
        bcu_result_t got;
        bcu_result_t want;

        got = word[49:0];
        if (block_q.size() == 0)
        begin
            errors++;
            if (shown < 10)
                $display("%0t: unexpected word row %0d col %0d px %0d %0d %0d %0d",
                         $realtime, got.out_row, got.out_col, got.px_even_even,
                         got.px_even_odd, got.px_odd_even, got.px_odd_odd);
            shown++;
            return;
        end
        want = block_q.pop_front();
        if (got !== want || word[55:50] !== 6'd0)
        begin
            errors++;
            if (shown < 10)
            begin
                $display("%0t: mismatch expected row %0d col %0d px %0d %0d %0d %0d",
                         $realtime, want.out_row, want.out_col, want.px_even_even,
                         want.px_even_odd, want.px_odd_even, want.px_odd_odd);
                $display("%0t:          actual   row %0d col %0d px %0d %0d %0d %0d pad %h",
                         $realtime, got.out_row, got.out_col, got.px_even_even,
                         got.px_even_odd, got.px_odd_even, got.px_odd_odd, word[55:50]);
            end
            shown++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < MAX_WIDTH; j++)
                    line_mem[i][j] = 8'd0;
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                    win[i][j] = 8'd0;
            row_pos    = 0;
            col_pos    = 0;
            width_reg  = 9'd256;
            height_reg = 9'd256;
            block_q.delete();
            errors     = 0;
            shown      = 0;
            pending    = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    WIDTH_ADDR:  width_reg  = pwdata[8:0];
                    HEIGHT_ADDR: height_reg = pwdata[8:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
                check_block(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                upscale_pixel(s_axis_tdata, s_axis_tuser);
            pending = block_q.size();
        end
    end

endmodule

[tb/tb_bicubic_upscale_2x.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bicubic_upscale_2x: testbench for the 2x bicubic upscaler
// Streams source frames in raster order under a range of image sizes: a
// directed pair of 4x4 frames that drive every filter output to both clamp
// limits, then random frames with occasional restarts, from the smallest
// size up to full width. Sender bursts and receiver stalls are random, with
// one long receiver hold-off. Checking is done by bicubic_checker.
// ----------------------------------------------------------------------------
module tb_bicubic_upscale_2x;

    localparam int         MAX_WIDTH       = 256;
    localparam logic [2:0] ADDR_SRC_WIDTH  = 3'h0;
    localparam logic [2:0] ADDR_SRC_HEIGHT = 3'h4;
    localparam int         STALL_LIMIT     = 3000;
    localparam int         DRAIN_CYCLES    = 16;
    localparam int         HOLD_CYCLES     = 400;
    localparam int         HOLD_AFTER      = 200;
    localparam int         NUM_PHASES      = 7;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_t;

    // register values as written, out-of-range ones included
    int phase_width  [NUM_PHASES] = '{8, 5, 4, 16, 12, 511, 7};
    int phase_height [NUM_PHASES] = '{6, 511, 4, 9, 5, 4, 3};
    int phase_pixels [NUM_PHASES] = '{80, 200, 50, 120, 50, 260, 60};

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] pixel
    logic        s_axis_tuser;    // [0] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;    // [8:0] out_row, [17:9] out_col, [25:18] px_even_even,
                                  // [33:26] px_even_odd, [41:34] px_odd_even,
                                  // [49:42] px_odd_odd
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int idle_cycles;
    int pixels_in;
    int burst_left;

    bicubic_upscale_2x #(.MAX_WIDTH(MAX_WIDTH)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    bicubic_checker #(
        .MAX_WIDTH   (MAX_WIDTH),
        .WIDTH_ADDR  (ADDR_SRC_WIDTH),
        .HEIGHT_ADDR (ADDR_SRC_HEIGHT)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // progress watchdog and input count
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
            pixels_in   <= 0;
        end
        else
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable && pwrite && pready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (s_axis_tvalid && s_axis_tready)
                pixels_in <= pixels_in + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // result side: stall patterns of random length, one long hold-off in the
    // middle of a long frame while the sender still has words to offer
    initial
    begin
        rx_mode_t mode;
        int       span;
        logic     held_off;

        held_off      = 1'b0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!held_off && pixels_in >= HOLD_AFTER)
            begin
                held_off = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                    m_axis_tready <= 1'b0;
                end
            end
            mode = rx_mode_t'($urandom_range(0, 2));
            span = $urandom_range(20, 150);
            for (int k = 0; k < span; k++)
            begin
                if (!held_off && pixels_in >= HOLD_AFTER)
                    break;
                @(negedge clk);
                case (mode)
                    RX_OPEN:     m_axis_tready <= 1'b1;
                    RX_RANDOM:   m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: m_axis_tready <= (k % 4 != 3);
                    default:     m_axis_tready <= 1'b1;
                endcase
            end
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // offers one pixel word, pacing the stream in bursts with random gaps
    task automatic feed_pixel(input logic [7:0] pix, input logic frame_start);
        int gap;

        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= frame_start;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // lets every queued block out, then the pipeline run dry
    task automatic drain_block();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        int         cur_width;
        int         new_width;
        logic       grow;
        logic       inner;
        logic       fs;
        logic [7:0] pix;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 3'd0;
        pwdata        = 32'd0;
        burst_left    = 0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // both sizes below the minimum; upper bus bits must be ignored
        write_reg(ADDR_SRC_WIDTH, 32'hFFFF_FE02);
        write_reg(ADDR_SRC_HEIGHT, 32'h0000_0001);
        cur_width = 4;

        // bright center then bright border: all filter outputs hit both clamps;
        // the second frame follows by row wrap without a frame start
        for (int f = 0; f < 2; f++)
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                begin
                    inner = (i == 1 || i == 2) && (j == 1 || j == 2);
                    feed_pixel((inner ^ (f == 1)) ? 8'd255 : 8'd0, f == 0 && i == 0 && j == 0);
                end
        drain_block();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(ADDR_SRC_WIDTH, 32'(phase_width[p]));
            write_reg(ADDR_SRC_HEIGHT, 32'(phase_height[p]));
            new_width = (phase_width[p] < 4) ? 4
                      : (phase_width[p] > MAX_WIDTH) ? MAX_WIDTH : phase_width[p];
            // a wider line than before restarts the frame so that no unwritten
            // line memory reaches a result; a narrower one continues the raster
            grow      = new_width > cur_width;
            cur_width = new_width;
            for (int n = 0; n < phase_pixels[p]; n++)
            begin
                fs = (n == 0 && grow) || ($urandom_range(0, 149) == 0);
                case ($urandom_range(0, 4))
                    0:       pix = 8'd0;
                    1:       pix = 8'd255;
                    default: pix = 8'($urandom_range(0, 255));
                endcase
                feed_pixel(pix, fs);
            end
            drain_block();
        end

        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
hdl/bcu_pkg.sv
hdl/bcu_front.sv
hdl/bcu_queue.sv
hdl/bcu_back.sv
hdl/bicubic_upscale_2x.sv
tb/bicubic_checker.sv
tb/tb_bicubic_upscale_2x.sv
